[rtl/core/spdt_pkg.sv]
`default_nettype none

package spdt_pkg;

  // request kinds
  typedef enum logic [1:0] {
    KIND_PUSH     = 2'd0,
    KIND_TRANSFER = 2'd1,
    KIND_DISPATCH = 2'd2,
    KIND_REPORT   = 2'd3
  } kind_t;

  // entry marks as stored in the table
  typedef enum logic [1:0] {
    MARK_NONE       = 2'd0,
    MARK_RECEIVED   = 2'd1,
    MARK_WAITING    = 2'd2,
    MARK_DISPATCHED = 2'd3
  } mark_t;

  // result status codes
  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_STACK_EMPTY = 3'd1,
    STATUS_QUEUE_EMPTY = 3'd2,
    STATUS_NONE_READY  = 3'd3,
    STATUS_FULL        = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_T_MOD,
    S_T_SCAN,
    S_D_SCAN,
    S_D_MARK,
    S_F_SCAN,
    S_DONE
  } state_t;

  localparam int PRIO_BITS = 2;
  localparam int MARK_BITS = 2;

endpackage

`default_nettype wire

[rtl/core/spdt_entry_ram.sv]
`default_nettype none

module spdt_entry_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 20,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/staged_priority_dispatch_table.sv]
`default_nettype none

// Staged priority dispatch table. Each request (push, transfer, dispatch or
// report) yields one result carrying a status, the affected entry and the
// table counters after the request. Requests are taken one at a time; all
// entry state sits in a single memory with one read and one write port, and
// every scan visits one entry per cycle through that read port. Push and
// report go straight to the done state, as do a transfer with an empty
// stack and a dispatch with an empty window; any other transfer marks the
// old stack top waiting and then scans the entries below it for the new
// top; any other dispatch scans the queue window, marks the best entry and,
// if that entry was the front, scans on to move the front. A result waits
// in the output register while the next request is accepted. The memory
// needs no clearing after reset.
module staged_priority_dispatch_table #(
  parameter int TABLE_DEPTH = 64,
  parameter int ID_BITS     = 16,
  localparam int IW = $clog2(TABLE_DEPTH),
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire spdt_pkg::kind_t         kind,
  input  wire logic [ID_BITS-1:0]      package_id,
  input  wire logic [1:0]              priority_req,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output spdt_pkg::status_t            status,
  output logic      [ID_BITS-1:0]      result_id,
  output logic      [1:0]              result_priority,
  output logic      [IW-1:0]           result_index,
  output logic      [CW-1:0]           received_count,
  output logic      [CW-1:0]           waiting_count,
  output logic      [CW-1:0]           dispatched_count,
  output logic      [CW-1:0]           front_index,
  output logic      [CW-1:0]           end_index,
  output logic      [IW-1:0]           top_index,
  output logic                         top_valid
);

  import spdt_pkg::*;

  localparam int EW = ID_BITS + PRIO_BITS + MARK_BITS;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // table state
  state_t          state, state_next;
  logic [CW-1:0]   fill_count;
  logic [IW-1:0]   stack_top;
  logic            stack_valid;
  logic [CW-1:0]   queue_front;
  logic [CW-1:0]   queue_end;
  logic [CW-1:0]   count_received;
  logic [CW-1:0]   count_waiting;
  logic [CW-1:0]   count_dispatched;
  logic            hit;

  // scan and result staging
  logic [CW-1:0]       ptr;
  logic [IW-1:0]       sel_idx;
  logic [ID_BITS-1:0]  best_id;
  logic [1:0]          best_prio;
  status_t             res_status;
  logic [ID_BITS-1:0]  res_id;
  logic [1:0]          res_prio;
  logic [IW-1:0]       res_idx;

  // memory ports
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  logic [EW-1:0]   mem_wdata;
  logic [IW-1:0]   mem_raddr;
  logic [EW-1:0]   mem_rdata;

  logic [ID_BITS-1:0] rd_id;
  logic [1:0]         rd_prio;
  mark_t              rd_mark;

  logic accept;
  logic out_free;
  logic cand;
  logic [CW-1:0] top_plus;
  logic [CW-1:0] ptr_plus;
  logic [CW-1:0] front_plus;

  spdt_entry_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (EW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_id   = mem_rdata[EW-1:PRIO_BITS+MARK_BITS];
  assign rd_prio = mem_rdata[PRIO_BITS+MARK_BITS-1:MARK_BITS];
  assign rd_mark = mark_t'(mem_rdata[MARK_BITS-1:0]);

  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign top_plus   = CW'(stack_top) + ONE_C;
  assign ptr_plus   = ptr + ONE_C;
  assign front_plus = queue_front + ONE_C;

  // dispatch candidate: waiting, valid priority, strictly better than best
  assign cand = (rd_mark == MARK_WAITING) && (rd_prio != 2'd0) &&
                (!hit || (rd_prio < best_prio));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (kind)
            KIND_TRANSFER: state_next = stack_valid ? S_T_MOD : S_DONE;
            KIND_DISPATCH: state_next = (queue_front >= queue_end) ? S_DONE : S_D_SCAN;
            default:       state_next = S_DONE;
          endcase
        end
      end
      S_T_MOD:  state_next = (stack_top == '0) ? S_DONE : S_T_SCAN;
      S_T_SCAN: begin
        if ((rd_mark == MARK_RECEIVED) || (ptr == '0)) state_next = S_DONE;
      end
      S_D_SCAN: begin
        if (ptr_plus >= queue_end) state_next = S_D_MARK;
      end
      S_D_MARK: begin
        if (hit && (CW'(sel_idx) == queue_front) && (front_plus < queue_end)) begin
          state_next = S_F_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_F_SCAN: begin
        if ((rd_mark == MARK_WAITING) || (ptr_plus >= queue_end)) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory control and input handshake
  always_comb begin
    in_stall  = (state != S_IDLE);
    mem_we    = 1'b0;
    mem_waddr = fill_count[IW-1:0];
    mem_wdata = {package_id, priority_req, MARK_RECEIVED};
    mem_raddr = stack_top;
    unique case (state)
      S_IDLE: begin
        mem_we    = in_valid && (kind == KIND_PUSH) && (fill_count < DEPTH_C);
        mem_raddr = (kind == KIND_DISPATCH) ? queue_front[IW-1:0] : stack_top;
      end
      S_T_MOD: begin
        mem_we    = 1'b1;
        mem_waddr = stack_top;
        mem_wdata = {rd_id, rd_prio, MARK_WAITING};
        mem_raddr = stack_top - IW'(1);
      end
      S_T_SCAN: mem_raddr = ptr[IW-1:0] - IW'(1);
      S_D_SCAN: mem_raddr = ptr_plus[IW-1:0];
      S_D_MARK: begin
        mem_we    = hit;
        mem_waddr = sel_idx;
        mem_wdata = {best_id, best_prio, MARK_DISPATCHED};
        mem_raddr = front_plus[IW-1:0];
      end
      S_F_SCAN: mem_raddr = ptr_plus[IW-1:0];
      default: mem_raddr = stack_top;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      fill_count       <= '0;
      stack_top        <= '0;
      stack_valid      <= 1'b0;
      queue_front      <= '0;
      queue_end        <= '0;
      count_received   <= '0;
      count_waiting    <= '0;
      count_dispatched <= '0;
      hit              <= 1'b0;
    end else begin
      state <= state_next;
      // hold a stalled result, raise valid when a new one is loaded
      out_valid <= ((state == S_DONE) && out_free) || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          hit <= 1'b0;
          if (accept && (kind == KIND_PUSH) && (fill_count < DEPTH_C)) begin
            stack_top      <= fill_count[IW-1:0];
            stack_valid    <= 1'b1;
            fill_count     <= fill_count + ONE_C;
            count_received <= count_received + ONE_C;
          end
        end
        S_T_MOD: begin
          if ((rd_mark == MARK_RECEIVED) && (count_received != '0)) begin
            count_received <= count_received - ONE_C;
          end
          count_waiting <= count_waiting + ONE_C;
          if (top_plus > queue_end) queue_end <= top_plus;
          stack_valid <= 1'b0;
          stack_top   <= '0;
        end
        S_T_SCAN: begin
          if (rd_mark == MARK_RECEIVED) begin
            stack_top   <= ptr[IW-1:0];
            stack_valid <= 1'b1;
          end
        end
        S_D_SCAN: begin
          if (cand) hit <= 1'b1;
        end
        S_D_MARK: begin
          if (hit) begin
            if (count_waiting != '0) count_waiting <= count_waiting - ONE_C;
            count_dispatched <= count_dispatched + ONE_C;
            if ((CW'(sel_idx) == queue_front) && (front_plus >= queue_end)) begin
              queue_front <= front_plus;
            end
          end
        end
        S_F_SCAN: begin
          if (rd_mark == MARK_WAITING) begin
            queue_front <= ptr;
          end else if (ptr_plus >= queue_end) begin
            queue_front <= ptr_plus;
          end
        end
        default: ;
      endcase
    end
  end

  // scan pointers, result staging and output register
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        ptr <= queue_front;
        if ((kind == KIND_PUSH) && (fill_count < DEPTH_C)) begin
          res_id   <= package_id;
          res_prio <= priority_req;
          res_idx  <= fill_count[IW-1:0];
        end else begin
          res_id   <= '0;
          res_prio <= '0;
          res_idx  <= '0;
        end
        unique case (kind)
          KIND_PUSH:     res_status <= (fill_count < DEPTH_C) ? STATUS_OK : STATUS_FULL;
          KIND_TRANSFER: res_status <= stack_valid ? STATUS_OK : STATUS_STACK_EMPTY;
          KIND_DISPATCH: begin
            res_status <= (queue_front >= queue_end) ? STATUS_QUEUE_EMPTY : STATUS_OK;
          end
          default:       res_status <= STATUS_OK;
        endcase
      end
      S_T_MOD: begin
        res_id   <= rd_id;
        res_prio <= rd_prio;
        res_idx  <= stack_top;
        ptr      <= CW'(stack_top) - ONE_C;
      end
      S_T_SCAN: ptr <= ptr - ONE_C;
      S_D_SCAN: begin
        if (cand) begin
          sel_idx   <= ptr[IW-1:0];
          best_id   <= rd_id;
          best_prio <= rd_prio;
        end
        ptr <= ptr_plus;
      end
      S_D_MARK: begin
        if (hit) begin
          res_id   <= best_id;
          res_prio <= best_prio;
          res_idx  <= sel_idx;
        end else begin
          res_status <= STATUS_NONE_READY;
        end
        ptr <= front_plus;
      end
      S_F_SCAN: ptr <= ptr_plus;
      S_DONE: begin
        if (out_free) begin
          status           <= res_status;
          result_id        <= res_id;
          result_priority  <= res_prio;
          result_index     <= res_idx;
          received_count   <= count_received;
          waiting_count    <= count_waiting;
          dispatched_count <= count_dispatched;
          front_index      <= queue_front;
          end_index        <= queue_end;
          top_index        <= stack_valid ? stack_top : '0;
          top_valid        <= stack_valid;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
